// ===== rtl/pwmlc_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmlc_pkg: shared types and constants for the PWM LED controller
// Request and response words, register map codes and count byte helpers.
// ----------------------------------------------------------------------------
package pwmlc_pkg;

	// Widths of the response fields, fixed by the interface
	localparam int OUT_CHANNELS   = 16;
	localparam int OUT_COUNT_BITS = 12;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef struct packed {
		req_type_t   req_type;
		logic [7:0]  reg_address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [7:0]                read_data;
		logic [OUT_CHANNELS-1:0]   pwm_outputs;
		logic [OUT_COUNT_BITS-1:0] counter_value;
	} rsp_t;

	// 13-bit channel count: bit 12 is the full flag
	typedef logic [12:0] count_t;
	localparam int FULL_BIT = 12;

	// Register map
	localparam logic [7:0] ADDR_MODE1    = 8'h00;
	localparam logic [7:0] ADDR_MODE2    = 8'h01;
	localparam logic [7:0] ADDR_SUB0     = 8'h02;
	localparam logic [7:0] ADDR_SUB3     = 8'h05;
	localparam logic [7:0] ADDR_CHAN0    = 8'h06;
	localparam logic [7:0] ADDR_ALL      = 8'hFA;
	localparam logic [7:0] ADDR_ALL_LAST = 8'hFD;
	localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

	// Mode1 bits, reset values and the prescale floor
	localparam int         MODE_RESTART_BIT = 7;
	localparam int         MODE_SLEEP_BIT   = 4;
	localparam logic [7:0] MODE1_RESET      = 8'h11;
	localparam logic [7:0] PRESCALE_RESET   = 8'd30;
	localparam logic [7:0] PRESCALE_MIN     = 8'd3;
	localparam count_t     ON_RESET         = 13'h0000;
	localparam count_t     OFF_RESET        = 13'h1000;

	// Replace the low or high byte of a count; the high byte carries bits 12..8
	function automatic count_t put_byte(input count_t cnt, input logic hi,
		input logic [7:0] d);
		count_t r;
		if (hi) begin
			r = {d[4:0], cnt[7:0]};
		end else begin
			r = {cnt[12:8], d};
		end
		return r;
	endfunction

	function automatic logic [7:0] get_byte(input count_t cnt, input logic hi);
		logic [7:0] r;
		if (hi) begin
			r = {3'b000, cnt[12:8]};
		end else begin
			r = cnt[7:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/pwmlc_levels.sv =====
// ----------------------------------------------------------------------------
// pwmlc_levels: per-channel output level compare
// Compares the period counter against each channel's on and off counts.
// ----------------------------------------------------------------------------
module pwmlc_levels import pwmlc_pkg::*; #(
	parameter int CHANNELS   = 16,
	parameter int COUNT_BITS = 12
) (
	input  logic                  sleep,
	input  count_t                on_counts  [CHANNELS],
	input  count_t                off_counts [CHANNELS],
	input  logic [COUNT_BITS-1:0] counter,
	output logic [CHANNELS-1:0]   levels
);

	always_comb begin
		logic [COUNT_BITS-1:0] on_c;
		logic [COUNT_BITS-1:0] off_c;
		for (int n = 0; n < CHANNELS; n++) begin
			on_c  = on_counts[n][COUNT_BITS-1:0];
			off_c = off_counts[n][COUNT_BITS-1:0];
			if (sleep || off_counts[n][FULL_BIT]) begin
				levels[n] = 1'b0;
			end else if (on_counts[n][FULL_BIT]) begin
				levels[n] = 1'b1;
			end else if (on_c < off_c) begin
				levels[n] = (counter >= on_c) && (counter < off_c);
			end else if (on_c > off_c) begin
				// window wraps round the end of the period
				levels[n] = (counter >= on_c) || (counter < off_c);
			end else begin
				levels[n] = 1'b0;
			end
		end
	end

endmodule

// ===== rtl/pwm_led_controller_registers.sv =====
// ----------------------------------------------------------------------------
// pwm_led_controller_registers: 16-channel PWM LED controller register model
// Byte register reads and writes and oscillator ticks, one word per request.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one word per item: a register write, a register
//   read or one oscillator tick. The rsp channel returns exactly one word per
//   request: the read byte (zero unless a read of a readable address), the
//   channel output levels and the period counter, all as they stand after the
//   request has taken effect.
//   A request taken is captured in the input register and applied to the
//   register file once the output register can take its response, which is
//   loaded into the output register at the same edge. Throughput is one
//   request per clock while rsp_ready stays high, set by the single compare
//   and update pass between the input register and the output register.
//   When rsp_ready is low the response word holds and the input register
//   keeps its word; req_ready stays high as long as the input register is
//   empty or moving on, so at most two words wait inside.
//   Reset puts mode1 at sleep with all-call, mode2 and sub-addresses at zero,
//   every channel full off, prescale at thirty and the divider and counter
//   at zero; both channels come up empty.
// ----------------------------------------------------------------------------
module pwm_led_controller_registers import pwmlc_pkg::*; #(
	parameter int CHANNELS   = 16,
	parameter int COUNT_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int          CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [8:0]  CHAN_END = 9'(ADDR_CHAN0) + 9'(4 * CHANNELS);

	// Input register
	req_t req_s1;
	logic valid_s1;
	logic fire_s1;
	logic out_free;

	// Register file
	logic [7:0]            mode1_q, mode1_d;
	logic [7:0]            mode2_q, mode2_d;
	logic [7:0]            sub_q [4];
	logic [7:0]            sub_d [4];
	count_t                on_q  [CHANNELS];
	count_t                on_d  [CHANNELS];
	count_t                off_q [CHANNELS];
	count_t                off_d [CHANNELS];
	logic [7:0]            prescale_q, prescale_d;
	logic [7:0]            div_q, div_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;

	// Output register
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic [7:0]          rdata;
	logic [CHANNELS-1:0] lvl;

	// Address decode
	logic [7:0]      addr;
	logic [7:0]      wdata;
	logic [7:0]      chan_off;
	logic [CH_W-1:0] chan_idx;
	logic            chan_hit;
	logic            all_hit;
	logic            sub_hit;
	logic [1:0]      all_sel;
	logic [1:0]      sub_idx;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign fire_s1   = valid_s1 && out_free;
	assign req_ready = !valid_s1 || out_free;

	assign addr     = req_s1.reg_address;
	assign wdata    = req_s1.write_data;
	assign chan_off = addr - ADDR_CHAN0;
	assign chan_idx = chan_off[CH_W+1:2];
	assign chan_hit = (addr >= ADDR_CHAN0) && ({1'b0, addr} < CHAN_END);
	assign all_hit  = (addr >= ADDR_ALL) && (addr <= ADDR_ALL_LAST);
	assign all_sel  = 2'(addr - ADDR_ALL);
	assign sub_hit  = (addr >= ADDR_SUB0) && (addr <= ADDR_SUB3);
	assign sub_idx  = 2'(addr - ADDR_SUB0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// Apply the request to the register file
	always_comb begin
		logic [7:0] nv;
		mode1_d    = mode1_q;
		mode2_d    = mode2_q;
		sub_d      = sub_q;
		on_d       = on_q;
		off_d      = off_q;
		prescale_d = prescale_q;
		div_d      = div_q;
		cnt_d      = cnt_q;
		rdata      = 8'h00;
		nv         = 8'h00;
		if (fire_s1) begin
			case (req_s1.req_type)
				REQ_WRITE: begin
					if (addr == ADDR_MODE1) begin
						// writing 1 to restart clears it; going to sleep sets it
						nv = {(wdata[MODE_RESTART_BIT] ? 1'b0 : mode1_q[MODE_RESTART_BIT]),
							wdata[6:0]};
						if (!mode1_q[MODE_SLEEP_BIT] && wdata[MODE_SLEEP_BIT]) begin
							nv[MODE_RESTART_BIT] = 1'b1;
						end
						mode1_d = nv;
					end else if (addr == ADDR_MODE2) begin
						mode2_d = wdata;
					end else if (sub_hit) begin
						sub_d[sub_idx] = wdata;
					end else if (addr == ADDR_PRESCALE) begin
						if (mode1_q[MODE_SLEEP_BIT]) begin
							prescale_d = (wdata < PRESCALE_MIN) ? PRESCALE_MIN : wdata;
						end
					end else if (chan_hit) begin
						for (int n = 0; n < CHANNELS; n++) begin
							if (chan_idx == CH_W'(n)) begin
								if (chan_off[1]) begin
									off_d[n] = put_byte(off_q[n], chan_off[0], wdata);
								end else begin
									on_d[n] = put_byte(on_q[n], chan_off[0], wdata);
								end
							end
						end
					end else if (all_hit) begin
						for (int n = 0; n < CHANNELS; n++) begin
							if (all_sel[1]) begin
								off_d[n] = put_byte(off_q[n], all_sel[0], wdata);
							end else begin
								on_d[n] = put_byte(on_q[n], all_sel[0], wdata);
							end
						end
					end
				end
				REQ_READ: begin
					if (addr == ADDR_MODE1) begin
						rdata = mode1_q;
					end else if (addr == ADDR_MODE2) begin
						rdata = mode2_q;
					end else if (sub_hit) begin
						rdata = sub_q[sub_idx];
					end else if (addr == ADDR_PRESCALE) begin
						rdata = prescale_q;
					end else if (chan_hit) begin
						rdata = chan_off[1] ? get_byte(off_q[chan_idx], chan_off[0])
							: get_byte(on_q[chan_idx], chan_off[0]);
					end
				end
				REQ_TICK: begin
					if (!mode1_q[MODE_SLEEP_BIT]) begin
						if (div_q >= prescale_q) begin
							div_d = 8'h00;
							cnt_d = cnt_q + 1'b1;
						end else begin
							div_d = div_q + 8'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode1_q    <= MODE1_RESET;
			mode2_q    <= 8'h00;
			prescale_q <= PRESCALE_RESET;
			div_q      <= 8'h00;
			cnt_q      <= '0;
			for (int i = 0; i < 4; i++) begin
				sub_q[i] <= 8'h00;
			end
			for (int n = 0; n < CHANNELS; n++) begin
				on_q[n]  <= ON_RESET;
				off_q[n] <= OFF_RESET;
			end
		end else begin
			mode1_q    <= mode1_d;
			mode2_q    <= mode2_d;
			prescale_q <= prescale_d;
			div_q      <= div_d;
			cnt_q      <= cnt_d;
			sub_q      <= sub_d;
			on_q       <= on_d;
			off_q      <= off_d;
		end
	end

	// Levels after the request's effect
	pwmlc_levels #(
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS)
	) u_levels (
		.sleep      (mode1_d[MODE_SLEEP_BIT]),
		.on_counts  (on_d),
		.off_counts (off_d),
		.counter    (cnt_d),
		.levels     (lvl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= fire_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp_q.read_data     <= rdata;
			rsp_q.pwm_outputs   <= OUT_CHANNELS'(lvl);
			rsp_q.counter_value <= OUT_COUNT_BITS'(cnt_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_prescale_floor: assert property (@(posedge clk) disable iff (!arst_n)
		prescale_q >= PRESCALE_MIN)
		else $error("prescale below minimum");

	a_sleep_holds_counter: assert property (@(posedge clk) disable iff (!arst_n)
		mode1_q[MODE_SLEEP_BIT] |=> $stable(cnt_q))
		else $error("counter moved while sleeping");

	a_stall_keeps_word: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid && !rsp_ready |=> valid_s1 && $stable(req_s1))
		else $error("input word dropped during output stall");

	a_read_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (req_s1.req_type != REQ_READ) |=> rsp.read_data == 8'h00)
		else $error("nonzero read data for a non-read request");

endmodule

// ===== tb/pwm_led_controller_registers_tb.sv =====
// ----------------------------------------------------------------------------
// pwm_led_controller_registers_tb: self-checking bench for the PWM LED registers
// A short run of hand-picked requests covers reset values, the prescale clamp,
// unmapped and write-only reads and the sleep and restart handling. A long
// random run of writes, reads and ticks follows. A cycle-free model of the
// register file and the period counter predicts every response word. Both
// handshakes idle at random, the receiver holds off once long enough to back
// up the request side, and the sender pauses now and then to let the block
// drain.
// ----------------------------------------------------------------------------
module pwm_led_controller_registers_tb;
	import pwmlc_pkg::*;

	localparam int         CHANS          = OUT_CHANNELS;
	localparam logic [7:0] ADDR_CHAN_END  = ADDR_CHAN0 + 8'd64;  // first address past channel 15
	localparam logic [7:0] ADDR_TOP       = 8'hFF;
	localparam int         SEGMENTS       = 18;
	localparam int         SEGMENT_ITEMS  = 100;
	localparam int         RX_HOLD_CYCLES = 400;
	localparam int         QUIET_LIMIT    = 3000;
	localparam int         DRAIN_CYCLES   = 8;

	// Hand-picked requests; want_rd is typed in only while the block sleeps,
	// so outputs and counter are zero on those rows
	typedef struct packed {
		req_t       word;
		logic       typed;
		logic [7:0] want_rd;
	} dir_row_t;

	localparam dir_row_t DIRECTED [25] = '{
		'{'{REQ_READ,  ADDR_MODE1,          8'h00}, 1'b1, MODE1_RESET},
		'{'{REQ_READ,  ADDR_PRESCALE,       8'h00}, 1'b1, PRESCALE_RESET},
		'{'{REQ_READ,  ADDR_CHAN0 + 8'd3,   8'h00}, 1'b1, 8'h10},
		'{'{REQ_READ,  ADDR_CHAN0 + 8'd63,  8'h00}, 1'b1, 8'h10},
		'{'{REQ_READ,  ADDR_CHAN_END,       8'hFF}, 1'b1, 8'h00},
		'{'{REQ_READ,  ADDR_ALL,            8'h00}, 1'b1, 8'h00},
		'{'{REQ_READ,  ADDR_TOP,            8'h00}, 1'b1, 8'h00},
		'{'{REQ_TICK,  ADDR_MODE1,          8'h00}, 1'b1, 8'h00},
		'{'{REQ_WRITE, ADDR_PRESCALE,       8'h00}, 1'b1, 8'h00},
		'{'{REQ_READ,  ADDR_PRESCALE,       8'h00}, 1'b1, PRESCALE_MIN},
		'{'{REQ_WRITE, ADDR_PRESCALE,       8'hFF}, 1'b1, 8'h00},
		'{'{REQ_READ,  ADDR_PRESCALE,       8'h00}, 1'b1, 8'hFF},
		'{'{REQ_WRITE, ADDR_PRESCALE,       8'h02}, 1'b1, 8'h00},
		'{'{REQ_READ,  ADDR_PRESCALE,       8'h00}, 1'b1, PRESCALE_MIN},
		// clear full off everywhere, then off count 2 on every channel
		'{'{REQ_WRITE, ADDR_ALL_LAST,       8'h00}, 1'b1, 8'h00},
		'{'{REQ_WRITE, ADDR_ALL + 8'd2,     8'h02}, 1'b1, 8'h00},
		// channel 0 full on, channel 1 full on and full off
		'{'{REQ_WRITE, ADDR_CHAN0 + 8'd1,   8'hFF}, 1'b1, 8'h00},
		'{'{REQ_WRITE, ADDR_CHAN0 + 8'd5,   8'hFF}, 1'b1, 8'h00},
		'{'{REQ_WRITE, ADDR_CHAN0 + 8'd7,   8'hFF}, 1'b0, 8'h00},
		'{'{REQ_WRITE, ADDR_MODE1,          8'h00}, 1'b0, 8'h00},
		'{'{REQ_TICK,  ADDR_TOP,            8'hFF}, 1'b0, 8'h00},
		'{'{REQ_WRITE, ADDR_PRESCALE,       8'h50}, 1'b0, 8'h00},
		'{'{REQ_WRITE, ADDR_MODE1,          8'h90}, 1'b0, 8'h00},
		'{'{REQ_READ,  ADDR_MODE1,          8'h00}, 1'b0, 8'h00},
		'{'{REQ_WRITE, ADDR_MODE1,          8'h80}, 1'b0, 8'h00}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Predicted register file and counter
	logic [7:0]  mode1_q;
	logic [7:0]  mode2_q;
	logic [7:0]  subaddr_q [4];
	count_t      on_q [CHANS];
	count_t      off_q [CHANS];
	logic [7:0]  prescale_q;
	logic [7:0]  divider_q;
	logic [11:0] period_q;

	rsp_t awaited_rsp [$];
	rsp_t head_rsp;
	int   mismatches   = 0;
	int   quiet_cycles = 0;
	bit   idling       = 1'b0;
	bit   rx_hold      = 1'b0;

	always #5 clk = ~clk;

	pwm_led_controller_registers i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	task automatic report_mismatch(input string what, input logic [15:0] want,
		input logic [15:0] got);
		if (mismatches < 100) begin
			$display("%0t: %s: expected %h, got %h", $time, what, want, got);
		end
		mismatches++;
	endtask

	function automatic void store_count_byte(input int ch, input logic [1:0] sel,
		input logic [7:0] d);
		count_t c;
		c = sel[1] ? off_q[ch] : on_q[ch];
		if (sel[0]) begin
			c[12:8] = d[4:0];
		end else begin
			c[7:0] = d;
		end
		if (sel[1]) begin
			off_q[ch] = c;
		end else begin
			on_q[ch] = c;
		end
	endfunction

	function automatic logic [15:0] channel_levels();
		logic [15:0] lv;
		logic [11:0] on_c;
		logic [11:0] off_c;
		bit          hi;
		lv = '0;
		if (mode1_q[MODE_SLEEP_BIT]) begin
			return lv;
		end
		for (int n = 0; n < CHANS; n++) begin
			on_c  = on_q[n][11:0];
			off_c = off_q[n][11:0];
			if (off_q[n][FULL_BIT]) begin
				hi = 1'b0;
			end else if (on_q[n][FULL_BIT]) begin
				hi = 1'b1;
			end else if (on_c < off_c) begin
				hi = period_q >= on_c && period_q < off_c;
			end else if (on_c > off_c) begin
				// wrap round the period
				hi = period_q >= on_c || period_q < off_c;
			end else begin
				hi = 1'b0;
			end
			lv[n] = hi;
		end
		return lv;
	endfunction

	function automatic rsp_t apply_request(input req_t w);
		rsp_t       r;
		logic [7:0] a;
		logic [7:0] d;
		logic [7:0] nv;
		logic [7:0] idx;
		logic [7:0] grp;
		count_t     c;
		a   = w.reg_address;
		d   = w.write_data;
		idx = a - ADDR_CHAN0;
		grp = a - ADDR_ALL;
		r   = '0;
		case (w.req_type)
			REQ_WRITE: begin
				if (a == ADDR_MODE1) begin
					nv = {1'b0, d[6:0]};
					if (!d[MODE_RESTART_BIT]) begin
						nv[MODE_RESTART_BIT] = mode1_q[MODE_RESTART_BIT];
					end
					if (!mode1_q[MODE_SLEEP_BIT] && d[MODE_SLEEP_BIT]) begin
						nv[MODE_RESTART_BIT] = 1'b1;
					end
					mode1_q = nv;
				end else if (a == ADDR_MODE2) begin
					mode2_q = d;
				end else if (a >= ADDR_SUB0 && a <= ADDR_SUB3) begin
					subaddr_q[2'(a - ADDR_SUB0)] = d;
				end else if (a >= ADDR_CHAN0 && a < ADDR_CHAN_END) begin
					store_count_byte(idx[5:2], idx[1:0], d);
				end else if (a >= ADDR_ALL && a <= ADDR_ALL_LAST) begin
					for (int n = 0; n < CHANS; n++) begin
						store_count_byte(n, grp[1:0], d);
					end
				end else if (a == ADDR_PRESCALE && mode1_q[MODE_SLEEP_BIT]) begin
					prescale_q = (d < PRESCALE_MIN) ? PRESCALE_MIN : d;
				end
			end
			REQ_READ: begin
				if (a == ADDR_MODE1) begin
					r.read_data = mode1_q;
				end else if (a == ADDR_MODE2) begin
					r.read_data = mode2_q;
				end else if (a >= ADDR_SUB0 && a <= ADDR_SUB3) begin
					r.read_data = subaddr_q[2'(a - ADDR_SUB0)];
				end else if (a >= ADDR_CHAN0 && a < ADDR_CHAN_END) begin
					c = idx[1] ? off_q[idx[5:2]] : on_q[idx[5:2]];
					r.read_data = idx[0] ? {3'b000, c[12:8]} : c[7:0];
				end else if (a == ADDR_PRESCALE) begin
					r.read_data = prescale_q;
				end
			end
			REQ_TICK: begin
				if (!mode1_q[MODE_SLEEP_BIT]) begin
					if (divider_q >= prescale_q) begin
						divider_q = '0;
						period_q  = period_q + 12'd1;
					end else begin
						divider_q = divider_q + 8'd1;
					end
				end
			end
			default: ;
		endcase
		r.pwm_outputs   = channel_levels();
		r.counter_value = period_q;
		return r;
	endfunction

	function automatic req_t draw_request();
		req_t       w;
		int         pick;
		logic [7:0] sel;
		w.req_type    = REQ_NONE;
		w.reg_address = 8'($urandom_range(0, 255));
		w.write_data  = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			w.req_type = REQ_TICK;
		end else if (pick < 68) begin
			w.req_type = REQ_READ;
			if ($urandom_range(0, 9) < 7) begin
				w.reg_address = 8'($urandom_range(0, 70));
			end
		end else if (pick >= 50) begin
			w.req_type = REQ_WRITE;
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				// mostly stay awake so ticks keep moving the counter
				w.reg_address = ADDR_MODE1;
				w.write_data[MODE_SLEEP_BIT] = ($urandom_range(0, 3) == 0);
			end else if (pick == 1) begin
				w.reg_address = ADDR_PRESCALE;
				if ($urandom_range(0, 3) != 0) begin
					w.write_data = 8'($urandom_range(0, 8));
				end
			end else if (pick < 4) begin
				w.reg_address = ADDR_ALL + 8'($urandom_range(0, 3));
			end else if (pick < 16) begin
				w.reg_address = ADDR_CHAN0 + 8'($urandom_range(0, 63));
			end
			// keep most counts within reach of the period counter
			if (pick >= 2 && pick < 16) begin
				sel = w.reg_address - ((pick < 4) ? ADDR_ALL : ADDR_CHAN0);
				if (sel[0] && $urandom_range(0, 9) < 6) begin
					w.write_data = 8'($urandom_range(0, 1));
				end else if (!sel[0] && $urandom_range(0, 9) < 3) begin
					w.write_data = 8'($urandom_range(0, 3));
				end
			end
		end
		return w;
	endfunction

	function automatic int gap_length();
		return ($urandom_range(0, 11) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	// Offer one word, hold it until taken, then predict its response
	task automatic send_word(input req_t w, input logic typed, input logic [7:0] want_rd);
		int   gap;
		rsp_t predicted;
		gap = (idling && $urandom_range(0, 2) == 0) ? gap_length() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predicted = apply_request(w);
		if (typed) begin
			predicted = '{want_rd, '0, '0};
		end
		awaited_rsp.push_back(predicted);
	endtask

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		mode1_q    = MODE1_RESET;
		mode2_q    = '0;
		prescale_q = PRESCALE_RESET;
		divider_q  = '0;
		period_q   = '0;
		foreach (subaddr_q[i]) subaddr_q[i] = '0;
		foreach (on_q[i]) begin
			on_q[i]  = ON_RESET;
			off_q[i] = OFF_RESET;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i]) begin
			send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want_rd);
		end
		for (int s = 0; s < SEGMENTS; s++) begin
			idling = (s % 3) != 0;
			if (s == 3) begin
				// receiver holds off while the sender keeps offering
				rx_hold = 1'b1;
			end
			if (s % 6 == 5) begin
				// drop valid and let every response come home
				req_valid <= 1'b0;
				@(posedge clk);
				while (awaited_rsp.size() != 0) @(posedge clk);
			end
			repeat (SEGMENT_ITEMS) send_word(draw_request(), 1'b0, 8'h00);
		end
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		forever begin
			if (rx_hold) begin
				rsp_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end else if (idling && $urandom_range(0, 2) == 0) begin
				rsp_ready <= 1'b0;
				repeat (gap_length()) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				report_mismatch("response word with nothing awaited", 16'h0000,
					rsp.pwm_outputs);
			end else begin
				head_rsp = awaited_rsp.pop_front();
				if (rsp.read_data !== head_rsp.read_data) begin
					report_mismatch("read_data", 16'(head_rsp.read_data),
						16'(rsp.read_data));
				end
				if (rsp.pwm_outputs !== head_rsp.pwm_outputs) begin
					report_mismatch("pwm_outputs", head_rsp.pwm_outputs, rsp.pwm_outputs);
				end
				if (rsp.counter_value !== head_rsp.counter_value) begin
					report_mismatch("counter_value", 16'(head_rsp.counter_value),
						16'(rsp.counter_value));
				end
			end
		end
	end

	// Give up when neither side moves a word for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
